// File: hw/rtl/swmt_pkg.sv
`timescale 1ns / 1ps

package swmt_pkg;

    localparam int unsigned VOTE_W  = 10;
    localparam int unsigned FIELD_W = 11;
    localparam int unsigned LEN_W   = 11;
    localparam int unsigned LIMIT_W = 10;
    localparam int unsigned APB_AW  = 3;
    localparam int unsigned APB_DW  = 32;

    localparam logic REG_WINDOW_LEN = 1'b0;
    localparam logic REG_BOOK_LIMIT = 1'b1;

    localparam logic [LEN_W-1:0]   WINDOW_LEN_RST = 11'd1024;
    localparam logic [LIMIT_W-1:0] BOOK_LIMIT_RST = 10'd1023;

    typedef struct packed {
        logic [VOTE_W-1:0] vote_id;
        logic              is_last;
    } t_vote_item;

    typedef struct packed {
        logic               window_full;
        logic [FIELD_W-1:0] window_top_id;
        logic [FIELD_W-1:0] window_top_count;
        logic [FIELD_W-1:0] best_id;
        logic [FIELD_W-1:0] best_count;
    } t_mode_result;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_RING,
        ST_INC,
        ST_OLDRD,
        ST_DEC,
        ST_SCAN,
        ST_SCAN_END,
        ST_DONE
    } t_state;

endpackage

// File: hw/rtl/sliding_window_mode_tracker_unit.sv
`timescale 1ns / 1ps

// Sliding-window mode tracker. Each transfer on the input channel carries one vote; the block
// keeps per-identifier counts over the most recent window_len votes in a count memory and a
// ring memory, and returns one result per vote: whether the window is full, the most frequent
// identifier in the window (smallest among ties) with its count once the window is full, and
// the best such pair over all full windows since the last clear. A vote is taken in the idle
// state and passes the reduce, ring and increment states, then the old-read and decrement
// states when the oldest vote leaves the window and, while the window is full, a scan of the
// single-port-read count memory, one entry per cycle, before its result is loaded in the done
// state; no new vote is taken until the block is back in idle. An identifier of NUM_IDS or
// more is reduced by repeated subtraction of NUM_IDS, and a result still held on the output
// stalls the block until it is taken. After reset and after every vote marked last, a
// clearing pass zeroes the count memory while no vote is accepted. The ring memory holds no
// reset value; only entries written since the last clear are read.
module sliding_window_mode_tracker_unit #(
    parameter int unsigned NUM_IDS    = 1024,
    parameter int unsigned MAX_WINDOW = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  swmt_pkg::t_vote_item      i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output swmt_pkg::t_mode_result    o_out_item,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [swmt_pkg::APB_AW-1:0] paddr,
    input  logic [swmt_pkg::APB_DW-1:0] pwdata,
    output logic [swmt_pkg::APB_DW-1:0] prdata,
    output logic                      pready
);
    import swmt_pkg::*;

    localparam int unsigned ID_W   = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
    localparam int unsigned RING_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);

    logic [LEN_W-1:0]   r_window_len;
    logic [LIMIT_W-1:0] r_book_limit;

    t_state r_state, n_state;

    logic [CNT_W-1:0]  count_mem [NUM_IDS];
    logic [ID_W-1:0]   ring_mem  [MAX_WINDOW];
    logic [CNT_W-1:0]  r_cnt_rdata;
    logic [ID_W-1:0]   r_ring_rdata;

    logic              cnt_we;
    logic [ID_W-1:0]   cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [ID_W-1:0]   cnt_raddr;
    logic              ring_we;

    logic [ID_W-1:0]   r_ptr;
    logic [VOTE_W-1:0] r_vid;
    logic              r_last;
    logic [ID_W-1:0]   r_old;
    logic [RING_W-1:0] r_head;
    logic [CNT_W-1:0]  r_fill;
    logic              r_evict;
    logic              r_full;
    logic              r_rv;
    logic [ID_W-1:0]   r_ridx;
    logic [ID_W-1:0]   r_top_id;
    logic [CNT_W-1:0]  r_top_cnt;
    logic [CNT_W-1:0]  r_best_cnt;
    logic [FIELD_W-1:0] r_best_id;
    logic              r_out_valid;
    t_mode_result      r_out;

    logic [ID_W-1:0]   cur_id;
    logic [CNT_W-1:0]  len_eff;
    logic              evict;
    logic [RING_W-1:0] old_pos;
    logic [RING_W-1:0] head_inc;
    logic [CNT_W-1:0]  fill_next;
    logic              cfg_wr;
    logic              ptr_end;
    logic              load_out;
    logic              take_best;
    logic [CNT_W-1:0]  n_best_cnt;
    logic [FIELD_W-1:0] n_best_id;
    logic [FIELD_W-1:0] limit_plus;

    assign cur_id     = ID_W'(r_vid);
    assign ptr_end    = (r_ptr == ID_W'(NUM_IDS - 1));
    assign limit_plus = FIELD_W'(r_book_limit) + FIELD_W'(1);
    assign cfg_wr     = psel && penable && pwrite;

    always_comb begin
        if (r_window_len == '0) begin
            len_eff = CNT_W'(1);
        end else if (32'(r_window_len) > MAX_WINDOW) begin
            len_eff = CNT_W'(MAX_WINDOW);
        end else begin
            len_eff = CNT_W'(r_window_len);
        end
    end

    assign evict     = ({1'b0, r_fill} + (CNT_W + 1)'(1)) > {1'b0, len_eff};
    assign fill_next = evict ? r_fill : r_fill + CNT_W'(1);
    assign head_inc  = (r_head == RING_W'(MAX_WINDOW - 1)) ? '0 : r_head + RING_W'(1);

    always_comb begin
        if ((CNT_W + 1)'(r_head) >= (CNT_W + 1)'(r_fill)) begin
            old_pos = RING_W'((CNT_W + 1)'(r_head) - (CNT_W + 1)'(r_fill));
        end else begin
            old_pos = RING_W'((CNT_W + 1)'(r_head) + (CNT_W + 1)'(MAX_WINDOW)
                              - (CNT_W + 1)'(r_fill));
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:    if (ptr_end) n_state = ST_IDLE;
            ST_IDLE:     if (i_in_valid) n_state = ST_REDUCE;
            ST_REDUCE:   if (32'(r_vid) < NUM_IDS) n_state = ST_RING;
            ST_RING:     n_state = ST_INC;
            ST_INC:      n_state = r_evict ? ST_OLDRD : (r_full ? ST_SCAN : ST_DONE);
            ST_OLDRD:    n_state = ST_DEC;
            ST_DEC:      n_state = r_full ? ST_SCAN : ST_DONE;
            ST_SCAN:     if (ptr_end) n_state = ST_SCAN_END;
            ST_SCAN_END: n_state = ST_DONE;
            ST_DONE:     if (!r_out_valid || i_out_ready) n_state = r_last ? ST_CLEAR : ST_IDLE;
            default:     n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = cur_id;
        cnt_wdata = '0;
        cnt_raddr = cur_id;
        ring_we   = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_ptr;
            end
            ST_RING: begin
                ring_we = 1'b1;
            end
            ST_INC: begin
                cnt_we    = 1'b1;
                cnt_wdata = r_cnt_rdata + CNT_W'(1);
            end
            ST_OLDRD: begin
                cnt_raddr = r_old;
            end
            ST_DEC: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_old;
                cnt_wdata = (r_cnt_rdata != '0) ? r_cnt_rdata - CNT_W'(1) : r_cnt_rdata;
            end
            ST_SCAN: begin
                cnt_raddr = r_ptr;
            end
            ST_DONE: begin
                load_out = !r_out_valid || i_out_ready;
            end
            default: begin
                cnt_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_rdata <= count_mem[cnt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring_mem[r_head] <= cur_id;
        end
        r_ring_rdata <= ring_mem[old_pos];
    end

    assign take_best = r_full && ((r_top_cnt > r_best_cnt) ||
                       ((r_top_cnt == r_best_cnt) && (FIELD_W'(r_top_id) < r_best_id)));
    assign n_best_cnt = take_best ? r_top_cnt : r_best_cnt;
    assign n_best_id  = take_best ? FIELD_W'(r_top_id) : r_best_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_window_len <= WINDOW_LEN_RST;
            r_book_limit <= BOOK_LIMIT_RST;
            r_ptr        <= '0;
            r_head       <= '0;
            r_fill       <= '0;
            r_best_cnt   <= '0;
            r_best_id    <= FIELD_W'(BOOK_LIMIT_RST) + FIELD_W'(1);
            r_out_valid  <= 1'b0;
            r_rv         <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rv    <= (r_state == ST_SCAN);
            r_ridx  <= r_ptr;

            if (cfg_wr) begin
                if (paddr[2] == REG_WINDOW_LEN) begin
                    r_window_len <= pwdata[LEN_W-1:0];
                end else begin
                    r_book_limit <= pwdata[LIMIT_W-1:0];
                    if (r_best_cnt == '0) begin
                        r_best_id <= FIELD_W'(pwdata[LIMIT_W-1:0]) + FIELD_W'(1);
                    end
                end
            end

            if (r_state == ST_CLEAR || r_state == ST_SCAN) begin
                r_ptr <= ptr_end ? '0 : r_ptr + ID_W'(1);
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_vid     <= i_in_item.vote_id;
                        r_last    <= i_in_item.is_last;
                        r_top_id  <= '0;
                        r_top_cnt <= '0;
                    end
                end
                ST_REDUCE: begin
                    if (32'(r_vid) >= NUM_IDS) begin
                        r_vid <= r_vid - VOTE_W'(NUM_IDS);
                    end
                end
                ST_RING: begin
                    r_evict <= evict;
                    r_full  <= (fill_next == len_eff);
                    r_fill  <= fill_next;
                    r_head  <= head_inc;
                end
                ST_INC: begin
                    r_old <= r_ring_rdata;
                end
                ST_DONE: begin
                    if (load_out && r_last) begin
                        r_head     <= '0;
                        r_fill     <= '0;
                        r_best_cnt <= '0;
                        r_best_id  <= limit_plus;
                    end else if (load_out) begin
                        r_best_cnt <= n_best_cnt;
                        r_best_id  <= n_best_id;
                    end
                end
                default: begin
                    r_evict <= r_evict;
                end
            endcase

            if (r_rv && (r_cnt_rdata > r_top_cnt)) begin
                r_top_cnt <= r_cnt_rdata;
                r_top_id  <= r_ridx;
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.window_full      <= r_full;
            r_out.window_top_id    <= FIELD_W'(r_top_id);
            r_out.window_top_count <= FIELD_W'(r_top_cnt);
            r_out.best_id          <= n_best_id;
            r_out.best_count       <= FIELD_W'(n_best_cnt);
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_BOOK_LIMIT) ? APB_DW'(r_book_limit)
                                                      : APB_DW'(r_window_len);

endmodule
